@@ src/skf_pkg.sv @@
// Types and constants shared by the scalar Kalman filter block.
// No dependencies.
package skf_pkg;

    localparam int ALU_W     = 35;
    localparam int CNT_W     = 5;
    localparam int GAIN_W    = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0]  LAST_STEP = 5'd16;
    localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROCESS_NOISE     = 2'd0,
        REG_MEASUREMENT_NOISE = 2'd1
    } cfg_reg_t;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_PRED  = 9'b000000010,
        ST_DENOM = 9'b000000100,
        ST_DIFF  = 9'b000001000,
        ST_DIV   = 9'b000010000,
        ST_MULE  = 9'b000100000,
        ST_ADDE  = 9'b001000000,
        ST_MULC  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic signed [31:0]    estimate;
        logic [GAIN_W-1:0]     gain;
    } skf_result_t;

endpackage

@@ src/skf_alu.sv @@
// Shared 35-bit adder/subtractor used for every arithmetic step.
// Depends on skf_pkg.
module skf_alu
    import skf_pkg::*;
(
    input  logic signed [ALU_W-1:0] a,
    input  logic signed [ALU_W-1:0] b,
    input  logic                    sub,
    output logic signed [ALU_W-1:0] sum
);

    assign sum = sub ? (a - b) : (a + b);

endmodule

@@ src/skf_core.sv @@
// Sequencer and state for the Kalman filter step: restoring divider and
// two shift-add multiplies, all on one shared adder. Depends on skf_pkg, skf_alu.
module skf_core
    import skf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] measurement,
    input  logic [31:0]        process_noise,
    input  logic [31:0]        measurement_noise,
    output logic               idle,
    output logic               res_valid,
    input  logic               res_ready,
    output skf_result_t        res
);

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [15:0]        meas_reg, meas_next;
    logic [31:0]               pred_reg, pred_next;
    logic [32:0]               denom_reg, denom_next;
    logic [33:0]               rem_reg, rem_next;
    logic [GAIN_W-1:0]         gain_reg, gain_next;
    logic                      dzero_reg, dzero_next;
    logic signed [33:0]        diff_reg, diff_next;
    logic signed [ALU_W-1:0]   acc_reg, acc_next;
    logic signed [31:0]        est_reg, est_next;
    logic [31:0]               cov_reg, cov_next;

    logic signed [ALU_W-1:0]   alu_a, alu_b, alu_sum;
    logic                      alu_sub;
    logic [GAIN_W-1:0]         cgain;
    logic                      last;

    skf_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    assign cgain = GAIN_ONE - gain_reg;
    assign last  = (cnt_reg == LAST_STEP);

    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_PRED:
            begin
                alu_a = $signed({3'b000, cov_reg});
                alu_b = $signed({3'b000, process_noise});
            end
            ST_DENOM:
            begin
                alu_a = $signed({3'b000, pred_reg});
                alu_b = $signed({3'b000, measurement_noise});
            end
            ST_DIFF:
            begin
                alu_a = $signed({{3{meas_reg[15]}}, meas_reg, 16'h0000});
                alu_b = $signed({{3{est_reg[31]}}, est_reg});
                alu_sub = 1'b1;
            end
            ST_DIV:
            begin
                alu_a = (cnt_reg == '0) ? $signed({1'b0, rem_reg})
                                        : $signed({rem_reg, 1'b0});
                alu_b = $signed({2'b00, denom_reg});
                alu_sub = 1'b1;
            end
            ST_MULE:
            begin
                alu_a = acc_reg;
                alu_b = gain_reg[cnt_reg] ? $signed({diff_reg[33], diff_reg})
                                          : '0;
            end
            ST_ADDE:
            begin
                alu_a = $signed({{3{est_reg[31]}}, est_reg});
                alu_b = acc_reg;
            end
            ST_MULC:
            begin
                alu_a = acc_reg;
                alu_b = cgain[cnt_reg] ? $signed({3'b000, pred_reg}) : '0;
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        meas_next  = meas_reg;
        pred_next  = pred_reg;
        denom_next = denom_reg;
        rem_next   = rem_reg;
        gain_next  = gain_reg;
        dzero_next = dzero_reg;
        diff_next  = diff_reg;
        acc_next   = acc_reg;
        est_next   = est_reg;
        cov_next   = cov_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    meas_next  = measurement;
                    state_next = ST_PRED;
                end
            end
            ST_PRED:
            begin
                pred_next  = alu_sum[32] ? 32'hFFFF_FFFF : alu_sum[31:0];
                state_next = ST_DENOM;
            end
            ST_DENOM:
            begin
                denom_next = alu_sum[32:0];
                dzero_next = (alu_sum[32:0] == '0);
                rem_next   = {2'b00, pred_reg};
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                diff_next  = alu_sum[33:0];
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring step: keep the trial remainder when non-negative
                gain_next = {gain_reg[GAIN_W-2:0], ~alu_sum[ALU_W-1]};
                rem_next  = alu_sum[ALU_W-1] ? alu_a[33:0] : alu_sum[33:0];
                cnt_next  = cnt_reg + 1'b1;
                if (last)
                begin
                    if (dzero_reg)
                        gain_next = '0;
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = ST_MULE;
                end
            end
            ST_MULE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last)
                begin
                    acc_next   = alu_sum;
                    state_next = ST_ADDE;
                end
                else
                    acc_next = alu_sum >>> 1;
            end
            ST_ADDE:
            begin
                est_next   = alu_sum[31:0];
                acc_next   = '0;
                cnt_next   = '0;
                state_next = ST_MULC;
            end
            ST_MULC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last)
                begin
                    cov_next   = alu_sum[31:0];
                    state_next = ST_DONE;
                end
                else
                    acc_next = alu_sum >>> 1;
            end
            ST_DONE:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            est_reg   <= '0;
            cov_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            est_reg   <= est_next;
            cov_reg   <= cov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg  <= meas_next;
        pred_reg  <= pred_next;
        denom_reg <= denom_next;
        rem_reg   <= rem_next;
        gain_reg  <= gain_next;
        dzero_reg <= dzero_next;
        diff_reg  <= diff_next;
        acc_reg   <= acc_next;
    end

    assign idle         = (state_reg == ST_IDLE);
    assign res_valid    = (state_reg == ST_DONE);
    assign res.estimate = est_reg;
    assign res.gain     = gain_reg;

endmodule

@@ src/scalar_kalman_filter_top.sv @@
// Top level of the scalar Kalman filter: configuration registers, input
// handshake and output register. Depends on skf_pkg, skf_core.
//
// Each accepted measurement yields one beat of estimate (signed Q16.16) and
// gain (Q1.16). A sample occupies the core from acceptance until its result
// is loaded into the output register, which waits while that register is
// full and out_ready is low; in_ready rises at that same edge, so the core
// takes one sample at a time. Each sample uses the single shared 35-bit
// adder for three set-up additions, 17 restoring divide steps for the gain,
// 17 shift-add steps for the estimate update, one final addition and 17
// shift-add steps for the new covariance. A finished result waits in the
// output register while the next sample is accepted. Write process_noise
// (index 0) and measurement_noise (index 1) only while idle; other indexes
// are ignored. Reset clears estimate, covariance and both noise registers.
module scalar_kalman_filter_top
    import skf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   measurement,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   estimate,
    output logic [GAIN_W-1:0]    gain,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic [31:0]       process_noise_reg, process_noise_next;
    logic [31:0]       measurement_noise_reg, measurement_noise_next;
    logic              out_valid_reg, out_valid_next;
    skf_result_t       out_reg, out_next;

    logic              core_idle;
    logic              res_valid;
    logic              res_ready;
    skf_result_t       res;

    skf_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (in_valid && in_ready),
        .measurement       (measurement),
        .process_noise     (process_noise_reg),
        .measurement_noise (measurement_noise_reg),
        .idle              (core_idle),
        .res_valid         (res_valid),
        .res_ready         (res_ready),
        .res               (res)
    );

    assign in_ready  = core_idle;
    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        process_noise_next     = process_noise_reg;
        measurement_noise_next = measurement_noise_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PROCESS_NOISE:     process_noise_next = cfg_data;
                REG_MEASUREMENT_NOISE: measurement_noise_next = cfg_data;
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_noise_reg     <= '0;
            measurement_noise_reg <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            process_noise_reg     <= process_noise_next;
            measurement_noise_reg <= measurement_noise_next;
            out_valid_reg         <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign estimate  = out_reg.estimate;
    assign gain      = out_reg.gain;

endmodule

@@ tb/tb_scalar_kalman_filter_top.sv @@
// Testbench for scalar_kalman_filter_top: checks estimate and gain beats against
// an in-bench fixed-point Kalman predictor under random idling and back-pressure.
// Depends on skf_pkg and scalar_kalman_filter_top.
`timescale 1ns / 1ps

module tb_scalar_kalman_filter_top;
    import skf_pkg::*;

    localparam int CLK_HALF_NS    = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int IDLE_PCT       = 7;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES   = 64;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_SAMPLES  = 72;
    localparam longint LIMIT_NS   = 64'd8_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [15:0]   measurement;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [31:0]   estimate;
    logic [GAIN_W-1:0]    gain;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    // predictor state and its copy of the noise registers
    logic signed [31:0] est_now = '0;
    logic [31:0]        cov_now = '0;
    logic [31:0]        q_now   = '0;
    logic [31:0]        r_now   = '0;

    skf_result_t pending_results[$];
    int          error_count = 0;
    bit          no_idle     = 1'b0;
    logic        rx_held     = 1'b0;
    event        start_holdoff;

    scalar_kalman_filter_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .estimate    (estimate),
        .gain        (gain),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #CLK_HALF_NS clk = ~clk;

    function automatic skf_result_t kalman_track(input logic signed [15:0] m);
        logic [32:0]       sum;
        logic [31:0]       pred;
        longint unsigned   denom;
        longint unsigned   g;
        longint unsigned   cov_wide;
        longint            diff;
        longint            est_wide;
        skf_result_t       res;
        sum   = {1'b0, cov_now} + {1'b0, q_now};
        pred  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        denom = {32'd0, pred} + {32'd0, r_now};
        g     = (denom == 0) ? 64'd0 : {16'd0, pred, 16'd0} / denom;
        if (g > 64'd65536)
            g = 64'd65536;
        est_wide = est_now;
        diff     = longint'(m) * 65536 - est_wide;
        est_wide = est_wide + ((longint'(g) * diff) >>> 16);
        cov_wide = ((64'd65536 - g) * {32'd0, pred}) >> 16;
        est_now  = est_wide[31:0];
        cov_now  = cov_wide[31:0];
        res.estimate = est_now;
        res.gain     = g[GAIN_W-1:0];
        return res;
    endfunction

    function automatic logic [31:0] pick_noise();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(255);
            3:       return $urandom_range(32'h0010_0000);
            default: return $urandom;
        endcase
    endfunction

    // beat sender; valid is left high so a following call can keep it asserted
    task automatic send_sample(input logic signed [15:0] m);
        if (!no_idle && $urandom_range(99) < 2 * IDLE_PCT) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        measurement <= m;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(kalman_track(m));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_PROCESS_NOISE)
            q_now = data;
        else if (idx == REG_MEASUREMENT_NOISE)
            r_now = data;
    endtask

    task automatic set_noise(input logic [31:0] q, input logic [31:0] r);
        write_reg(REG_PROCESS_NOISE, q);
        write_reg(REG_MEASUREMENT_NOISE, r);
    endtask

    // noisy level with the odd wild sample
    task automatic send_track(input int count);
        int level;
        int s;
        level = int'($urandom_range(60000)) - 30000;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) < 8)
                s = level + int'($urandom_range(64)) - 32;
            else
                s = int'($urandom);
            send_sample(s[15:0]);
        end
    endtask

    // reset values: Q and R both zero, so the denominator is zero
    task automatic test_zero_denominator();
        send_sample(16'sh7FFF);
        send_sample(-16'sh8000);
        send_sample(16'sd0);
    endtask

    task automatic test_full_gain_and_saturation();
        set_noise(32'hFFFF_FFFF, 32'd0);
        send_sample(16'sh7FFF);
        send_sample(-16'sh8000);
        send_sample(-16'sd1);
        write_reg(REG_MEASUREMENT_NOISE, 32'd1);
        send_sample(16'sd1);
        send_sample(16'sh5555);
        send_sample(-16'sh2AAB);
        set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(16'sh7FFF);
        send_sample(-16'sh8000);
        set_noise(32'd0, 32'd0);
        send_sample(16'sd1234);
        send_sample(-16'sd4321);
        set_noise(32'd0, 32'hFFFF_FFFF);
        send_sample(16'sh7FFF);
        send_sample(-16'sh8000);
    endtask

    task automatic test_unknown_register_index();
        set_noise(32'h0000_8000, 32'h0002_0000);
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        send_sample(16'sd100);
        send_sample(-16'sd100);
        send_sample(16'sh7FFF);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_noise(pick_noise(), pick_noise());
            send_track(PHASE_SAMPLES);
        end
    endtask

    task automatic test_quiet_stretch();
        set_noise(32'h0000_0400, 32'h0001_0000);
        wait_idle();
        no_idle = 1'b1;
        send_track(40);
        wait_idle();
        no_idle = 1'b0;
    endtask

    task automatic test_output_backpressure();
        set_noise(pick_noise(), pick_noise());
        -> start_holdoff;
        send_track(20);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        measurement = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_PROCESS_NOISE;
        cfg_data    = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_denominator();
        test_full_gain_and_saturation();
        test_unknown_register_index();
        test_random_settings();
        test_quiet_stretch();
        test_output_backpressure();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("** scalar_kalman_filter_top: PASSED **");
        else
            $display("** scalar_kalman_filter_top: FAILED **");
        $finish;
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
        out_ready <= !rx_held && (no_idle || $urandom_range(99) >= IDLE_PCT);

    initial
    begin
        forever
        begin
            @(start_holdoff);
            rx_held <= 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge clk);
            rx_held <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        skf_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected beat estimate=%0d gain=%0d",
                             $realtime, estimate, gain);
            end
            else
            begin
                want = pending_results.pop_front();
                if (estimate !== want.estimate || gain !== want.gain)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: mismatch estimate exp=%0d got=%0d gain exp=%0d got=%0d",
                                 $realtime, want.estimate, estimate, want.gain, gain);
                end
            end
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("** scalar_kalman_filter_top: FAILED **");
        $finish;
    end

endmodule

@@ scalar_kalman_filter_top.f @@
src/skf_pkg.sv
src/skf_alu.sv
src/skf_core.sv
src/scalar_kalman_filter_top.sv
tb/tb_scalar_kalman_filter_top.sv
